@@ rtl/core/sdtq_pkg.sv @@
// Package for the sorted deadline timer queue: sizes, entry type, status codes.
// Used by sdtq_store and sorted_deadline_timer_queue.
`timescale 1ns / 1ps
package sdtq_pkg;
   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_EXPIRE = 2'd1,
      MODE_FIND   = 2'd2,
      MODE_DELETE = 2'd3
   } mode_type;

   localparam logic [2:0] ST_ENTRY    = 3'd0;
   localparam logic [2:0] ST_NONE     = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_DELETED  = 3'd4;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] src;
      logic [31:0] dst;
      logic [7:0]  kind;
      logic [7:0]  retries;
      logic [31:0] deadline;
   } entry_type;

   // Memory commands from the sequencer.
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
   } mem_cmd_type;

   // True when deadline a lies strictly after deadline b, modulo 2^32.
   function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = b - a;
      return d[31];
   endfunction
endpackage

@@ rtl/core/sdtq_store.sv @@
// Entry memory of the timer queue: one write port, one registered read port.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps
module sdtq_store
   import sdtq_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type cmd,
   input  entry_type   wr_data,
   output entry_type   rd_data
);
   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule

@@ rtl/core/sorted_deadline_timer_queue.sv @@
// Sorted deadline timer queue top level: request decode, sequencer, result register.
// Depends on sdtq_pkg and sdtq_store.
`timescale 1ns / 1ps
// One request is worked on at a time. A slot is read and written through one memory port
// pair. Insert and find scan the slots from the head, and a delete also moves the later
// slots down once per removed entry. Expire pops due entries one at a time, and a held
// result stalls it.
// Reset clears the fill count and the sequencer; entry storage is left unwritten.
module sorted_deadline_timer_queue
   import sdtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[1:0], key_id[33:2], src_addr[65:34], dst_addr[97:66], task_kind[105:98],
   // retry_count[113:106], delay_ms[144:114], now_ms[176:145], zero fill to 184
   input  logic [183:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], out_id[34:3], out_src[66:35], out_dst[98:67], out_kind[106:99],
   // out_retries[114:107], out_deadline[146:115], removed_count[151:147]
   output logic [151:0] rsp_tdata,
   output logic         rsp_tlast
);
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EVAL, S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_OUT
   } state_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   entry_type        req_ff, req_in;       // captured request, deadline precomputed
   logic [31:0]      now_ff, now_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;       // scan index
   logic [CNT_W-1:0] ptr_ff, ptr_in;       // shift pointer
   logic [CNT_W-1:0] pos_ff, pos_in;       // insert position / removal slot
   logic [4:0]       cnt_ff, cnt_in;       // removed or popped count
   logic             pop_ff, pop_in;       // expire holds a popped entry in rd_ff
   logic             rv_ff, rv_in;
   logic             rl_ff, rl_in;
   logic [151:0]     rd_ff, rd_in;
   logic             back_ff, back_in;     // return state after output taken
   mem_cmd_type      cmd;
   entry_type        wdata, rdata;

   sdtq_store u_store (.clock(clock), .cmd(cmd), .wr_data(wdata), .rd_data(rdata));

   function automatic logic [151:0] pack_rsp(input logic [2:0] st, input entry_type e,
                                             input logic [4:0] rc);
      return {rc, e.deadline, e.retries, e.kind, e.dst, e.src, e.id, st};
   endfunction

   wire rsp_free = !rv_ff || rsp_tready;
   wire match = (rdata.id == req_ff.id) && (rdata.kind == req_ff.kind);

   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tlast  = rl_ff;

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; req_in = req_ff; now_in = now_ff;
      fill_in = fill_ff; idx_in = idx_ff; ptr_in = ptr_ff; pos_in = pos_ff;
      cnt_in = cnt_ff; pop_in = pop_ff; back_in = back_ff;
      rv_in = rv_ff && !rsp_tready; rl_in = rl_ff; rd_in = rd_ff;
      cmd = '0; wdata = req_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               mode_in = mode_type'(req_tdata[1:0]);
               req_in.id = req_tdata[33:2];
               req_in.src = req_tdata[65:34];
               req_in.dst = req_tdata[97:66];
               req_in.kind = req_tdata[105:98];
               req_in.retries = req_tdata[113:106];
               req_in.deadline = req_tdata[176:145] + {1'b0, req_tdata[144:114]};
               now_in = req_tdata[176:145];
               idx_in = '0; cnt_in = '0; pop_in = 1'b0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Start of a scan step: decide end conditions, else read slot idx.
            // While an earlier expire result still waits on the output, the scan
            // holds so that the result register is not overwritten.
            if (rv_ff) begin
               state_in = S_READ;
            end else if (mode_ff == MODE_INSERT && fill_ff >= CNT_W'(QUEUE_DEPTH)) begin
               rd_in = pack_rsp(ST_FULL, '0, '0); rl_in = 1'b1;
               state_in = S_OUT; back_in = 1'b0;
            end else if (idx_ff >= fill_ff ||
                         (mode_ff == MODE_EXPIRE && cnt_ff == 5'(MAX_RESULTS))) begin
               if (mode_ff == MODE_INSERT) begin
                  pos_in = idx_ff; ptr_in = fill_ff; state_in = S_SHIFT_RD;
               end else begin
                  rl_in = 1'b1; back_in = 1'b0; state_in = S_OUT;
                  // An expire that popped an entry sends that held entry as the last.
                  if (mode_ff == MODE_DELETE) rd_in = pack_rsp(ST_DELETED, '0, cnt_ff);
                  else if (!pop_ff) rd_in = pack_rsp(ST_NONE, '0, '0);
               end
            end else begin
               cmd.rd_en = 1'b1; cmd.rd_addr = idx_ff[IDX_W-1:0];
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            case (mode_ff)
               MODE_INSERT: begin
                  if (later_than(req_ff.deadline, rdata.deadline)) begin
                     idx_in = idx_ff + 1'b1; state_in = S_READ;
                  end else begin
                     pos_in = idx_ff; ptr_in = fill_ff; state_in = S_SHIFT_RD;
                  end
               end
               MODE_EXPIRE: begin
                  if (!later_than(rdata.deadline, now_ff)) begin
                     if (pop_ff) begin
                        // Another entry is due, so the held one is not the last.
                        rl_in = 1'b0; back_in = 1'b1; state_in = S_OUT;
                     end else begin
                        // Pop head; hold result until we know whether more follow.
                        rd_in = pack_rsp(ST_ENTRY, rdata, '0);
                        cnt_in = cnt_ff + 1'b1; pop_in = 1'b1;
                        pos_in = '0; ptr_in = '0; state_in = S_SHIFT_RD;
                     end
                  end else if (pop_ff) begin
                     rl_in = 1'b1; back_in = 1'b0; state_in = S_OUT;
                  end else begin
                     rd_in = pack_rsp(ST_NONE, '0, '0); rl_in = 1'b1;
                     back_in = 1'b0; state_in = S_OUT;
                  end
               end
               MODE_FIND: begin
                  if (match) begin
                     rd_in = pack_rsp(ST_ENTRY, rdata, '0); rl_in = 1'b1;
                     back_in = 1'b0; state_in = S_OUT;
                  end else begin
                     idx_in = idx_ff + 1'b1; state_in = S_READ;
                  end
               end
               default: begin
                  if (match) begin
                     cnt_in = cnt_ff + 1'b1;
                     pos_in = idx_ff; ptr_in = idx_ff; state_in = S_SHIFT_RD;
                  end else begin
                     idx_in = idx_ff + 1'b1; state_in = S_READ;
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (mode_ff == MODE_INSERT) begin
               // Move slots up from the tail down to pos.
               if (ptr_ff == pos_ff) begin
                  state_in = S_PUT;
               end else begin
                  cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(ptr_ff - 1'b1);
                  state_in = S_SHIFT_WR;
               end
            end else begin
               // Close the gap at pos by moving slots down.
               if (ptr_ff + 1'b1 >= fill_ff) begin
                  fill_in = fill_ff - 1'b1;
                  // Delete rescans the slot that moved in; expire looks at the new head.
                  state_in = S_READ;
               end else begin
                  cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(ptr_ff + 1'b1);
                  state_in = S_SHIFT_WR;
               end
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en = 1'b1; wdata = rdata;
            cmd.wr_addr = ptr_ff[IDX_W-1:0];
            if (mode_ff == MODE_INSERT) ptr_in = ptr_ff - 1'b1;
            else ptr_in = ptr_ff + 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_PUT: begin
            cmd.wr_en = 1'b1; cmd.wr_addr = pos_ff[IDX_W-1:0]; wdata = req_ff;
            fill_in = fill_ff + 1'b1;
            rd_in = pack_rsp(ST_INSERTED, '0, '0); rl_in = 1'b1;
            back_in = 1'b0; state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rv_in = 1'b1;
               if (back_ff && !rl_ff) begin
                  idx_in = '0; pop_in = 1'b0; state_in = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fill_ff <= '0; rv_ff <= 1'b0; rl_ff <= 1'b0;
         mode_ff <= MODE_INSERT; back_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; rv_ff <= rv_in; rl_ff <= rl_in;
         mode_ff <= mode_in; back_ff <= back_in; cnt_ff <= cnt_in;
      end
      req_ff <= req_in; now_ff <= now_in; idx_ff <= idx_in; ptr_ff <= ptr_in;
      pos_ff <= pos_in; pop_ff <= pop_in; rd_ff <= rd_in;
   end

   // A request is never taken while a result is still being built.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   // The fill count never exceeds the depth.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(QUEUE_DEPTH)) else $error("fill overflow");
   // A last result closes the request before the next one is taken.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && state_ff == S_OUT) |-> !req_tready)
      else $error("last overlap");
endmodule
